/* hdl/mrt_pkg.sv */
// Shared types, constants and codes for the mesh route table.
package mrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [31:0] TIMEOUT_RESET = 32'd3600000;
   localparam logic [7:0] HOP_LIMIT_RESET = 8'd48;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_HOP_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_LOOKUP = 3'd1,
      OP_SWEEP  = 3'd2,
      OP_READ   = 3'd3,
      OP_PURGE  = 3'd4
   } op_type;

   typedef struct packed {
      logic [31:0] node;
      logic [31:0] via;
      logic [7:0]  hops;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [31:0] timeout;
      logic [7:0]  hop_limit;
   } cfg_type;

   typedef struct packed {
      logic node_eq;
      logic via_eq;
      logic direct;
      logic stale;
   } cmp_type;

endpackage

/* hdl/mrt_req_if.sv */
// Request channel interface.
interface mrt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] dest_id;
   logic [31:0] via_hop;
   logic [7:0]  hop_count;
   logic [4:0]  entry_index;
   logic [31:0] now_ms;

   modport source(output valid, op, dest_id, via_hop, hop_count, entry_index, now_ms,
                  input ready);
   modport sink(input valid, op, dest_id, via_hop, hop_count, entry_index, now_ms,
                output ready);
endinterface

/* hdl/mrt_rsp_if.sv */
// Response channel interface.
interface mrt_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic        table_changed;
   logic [31:0] out_node;
   logic [31:0] out_via_hop;
   logic [7:0]  out_hop_count;
   logic [5:0]  entry_count;

   modport source(output valid, hit, table_changed, out_node, out_via_hop, out_hop_count,
                  entry_count, input ready);
   modport sink(input valid, hit, table_changed, out_node, out_via_hop, out_hop_count,
                entry_count, output ready);
endinterface

/* hdl/mrt_csr.sv */
// APB configuration registers: timeout and hop limit.
module mrt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mrt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output mrt_pkg::cfg_type                cfg
);
   import mrt_pkg::*;

   logic [31:0] timeout_ff, timeout_in;
   logic [7:0]  limit_ff, limit_in;
   logic        wr;

   assign pready = 1'b1;
   assign wr = psel & penable & pwrite;

   always_comb begin
      timeout_in = timeout_ff;
      limit_in = limit_ff;
      if (wr) begin
         if (paddr[2] == REG_TIMEOUT) timeout_in = pwdata;
         else limit_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         limit_ff <= HOP_LIMIT_RESET;
      end else begin
         timeout_ff <= timeout_in;
         limit_ff <= limit_in;
      end
   end

   assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_ff : {24'd0, limit_ff};
   assign cfg.timeout = timeout_ff;
   assign cfg.hop_limit = limit_ff;
endmodule

/* hdl/mrt_cmp_unit.sv */
// Shared entry compare unit: id match, next-hop match, expiry and hop limit.
module mrt_cmp_unit (
   input  mrt_pkg::entry_type ent,
   input  logic [31:0]        key,
   input  logic [31:0]        now,
   input  mrt_pkg::cfg_type   cfg,
   output mrt_pkg::cmp_type   res
);
   import mrt_pkg::*;

   logic [32:0] limit;

   assign limit = {1'b0, ent.stamp} + {1'b0, cfg.timeout};
   assign res.node_eq = (ent.node == key);
   assign res.via_eq = (ent.via == key);
   assign res.direct = (ent.via == 32'd0);
   assign res.stale = ({1'b0, now} > limit) || (ent.hops > cfg.hop_limit);
endmodule

/* hdl/mesh_route_table_core.sv */
// Top level: route table memory, scan/compaction sequencer and result register.
//
//  channel   dir  handshake        payload
//  req_bus   in   valid/ready      op, dest_id, via_hop, hop_count, entry_index, now_ms
//  rsp_bus   out  valid/ready      hit, table_changed, out_node, out_via_hop, ...
//  csr       in   APB psel/penable timeout (0x0), hop limit (0x4)
//
// Every table pass reads each entry from memory, then compares or writes it.
// Lookup: one search pass. Add: the search plus at most one compaction pass.
// Sweep: one scan plus one compaction pass per removed entry. Read: one memory read.
// Ready is high only in idle; a finished item waits in the result register.
// Reset clears the entry count; table contents need no clearing.
module mesh_route_table_core (
   input  logic                           clock,
   input  logic                           reset,
   mrt_req_if.sink                        req_bus,
   mrt_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mrt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import mrt_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_FIND_RD  = 13'b0000000000010,
      S_FIND_CHK = 13'b0000000000100,
      S_ADD_FULL = 13'b0000000001000,
      S_APPEND   = 13'b0000000010000,
      S_SWP_RD   = 13'b0000000100000,
      S_SWP_CHK  = 13'b0000001000000,
      S_CMP_RD   = 13'b0000010000000,
      S_CMP_CHK  = 13'b0000100000000,
      S_READ_RD  = 13'b0001000000000,
      S_READ_CHK = 13'b0010000000000,
      S_FINISH   = 13'b0100000000000,
      S_UNUSED   = 13'b1000000000000
   } state_type;

   cfg_type   cfg;
   cmp_type   cmp;
   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;
   logic [IDX_W-1:0] raddr, waddr;
   logic      rd_en, we;
   entry_type wdata;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, r_ff, r_in, w_ff, w_in, i_ff, i_in;
   logic [CNT_W-1:0] kidx_ff, kidx_in;
   logic      kidx_en_ff, kidx_en_in, kvia_en_ff, kvia_en_in;
   op_type    op_ff, op_in;
   logic [31:0] key_ff, key_in, via_ff, via_in, now_ff, now_in;
   logic [7:0]  hops_ff, hops_in;
   logic [4:0]  idx_ff, idx_in;
   logic      hit_ff, hit_in, chg_ff, chg_in;
   entry_type ent_ff, ent_in;
   logic      kill;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in, rsp_chg_ff, rsp_chg_in;
   logic [31:0] rsp_node_ff, rsp_node_in, rsp_via_ff, rsp_via_in;
   logic [7:0]  rsp_hops_ff, rsp_hops_in;
   logic [5:0]  rsp_cnt_ff, rsp_cnt_in;

   mrt_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   mrt_cmp_unit u_cmp (
      .ent(rdata_ff), .key(key_ff), .now(now_ff), .cfg(cfg), .res(cmp)
   );

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   assign kill = (kidx_en_ff && (r_ff == kidx_ff)) || (kvia_en_ff && cmp.via_eq);
   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; r_in = r_ff; w_in = w_ff; i_in = i_ff;
      kidx_in = kidx_ff; kidx_en_in = kidx_en_ff; kvia_en_in = kvia_en_ff;
      op_in = op_ff; key_in = key_ff; via_in = via_ff; now_in = now_ff;
      hops_in = hops_ff; idx_in = idx_ff;
      hit_in = hit_ff; chg_in = chg_ff; ent_in = ent_ff;
      rd_en = 1'b0; raddr = r_ff[IDX_W-1:0];
      we = 1'b0; waddr = w_ff[IDX_W-1:0]; wdata = rdata_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in = rsp_hit_ff; rsp_chg_in = rsp_chg_ff; rsp_node_in = rsp_node_ff;
      rsp_via_in = rsp_via_ff; rsp_hops_in = rsp_hops_ff; rsp_cnt_in = rsp_cnt_ff;

      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in = op_type'(req_bus.op);
               key_in = req_bus.dest_id;
               via_in = req_bus.via_hop;
               hops_in = req_bus.hop_count;
               idx_in = req_bus.entry_index;
               now_in = req_bus.now_ms;
               hit_in = 1'b0; chg_in = 1'b0; ent_in = '0;
               r_in = '0; w_in = '0; i_in = '0;
               kidx_en_in = 1'b0; kvia_en_in = 1'b0;
               unique case (op_type'(req_bus.op))
                  OP_ADD, OP_LOOKUP: state_in = S_FIND_RD;
                  OP_SWEEP: state_in = S_SWP_RD;
                  OP_READ: state_in = S_READ_RD;
                  OP_PURGE: begin
                     kvia_en_in = 1'b1;
                     state_in = S_CMP_RD;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_FIND_RD: begin
            if (r_ff >= cnt_ff) begin
               state_in = (op_ff == OP_ADD) ? S_ADD_FULL : S_FINISH;
            end else begin
               rd_en = 1'b1;
               state_in = S_FIND_CHK;
            end
         end
         S_FIND_CHK: begin
            if (!cmp.node_eq) begin
               r_in = r_ff + 1'b1;
               state_in = S_FIND_RD;
            end else if (op_ff == OP_LOOKUP) begin
               hit_in = 1'b1;
               ent_in = rdata_ff;
               state_in = S_FINISH;
            end else if (cmp.direct) begin
               if (via_ff == 32'd0) begin
                  we = 1'b1;
                  waddr = r_ff[IDX_W-1:0];
                  wdata.stamp = now_ff;
               end
               state_in = S_FINISH;
            end else if (via_ff != 32'd0 && rdata_ff.hops <= hops_ff) begin
               state_in = S_FINISH;
            end else begin
               kidx_en_in = 1'b1; kidx_in = r_ff;
               r_in = '0; w_in = '0;
               state_in = S_CMP_RD;
            end
         end
         S_ADD_FULL: begin
            if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
               kidx_en_in = 1'b1; kidx_in = '0; kvia_en_in = 1'b0;
               r_in = '0; w_in = '0;
               state_in = S_CMP_RD;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            we = 1'b1;
            waddr = cnt_ff[IDX_W-1:0];
            wdata.node = key_ff; wdata.via = via_ff;
            wdata.hops = hops_ff; wdata.stamp = now_ff;
            cnt_in = cnt_ff + 1'b1;
            chg_in = 1'b1;
            state_in = S_FINISH;
         end
         S_SWP_RD: begin
            if (i_ff >= cnt_ff) begin
               state_in = S_FINISH;
            end else begin
               rd_en = 1'b1;
               raddr = i_ff[IDX_W-1:0];
               state_in = S_SWP_CHK;
            end
         end
         S_SWP_CHK: begin
            if (cmp.stale) begin
               key_in = rdata_ff.node;
               kidx_en_in = 1'b1; kidx_in = i_ff;
               kvia_en_in = cmp.direct;
               chg_in = 1'b1;
               r_in = '0; w_in = '0;
               state_in = S_CMP_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SWP_RD;
            end
         end
         S_CMP_RD: begin
            if (r_ff >= cnt_ff) begin
               cnt_in = w_ff;
               priority case (op_ff)
                  OP_ADD: state_in = S_ADD_FULL;
                  OP_SWEEP: state_in = S_SWP_RD;
                  default: begin
                     chg_in = (w_ff != cnt_ff);
                     state_in = S_FINISH;
                  end
               endcase
            end else begin
               rd_en = 1'b1;
               state_in = S_CMP_CHK;
            end
         end
         S_CMP_CHK: begin
            if (kidx_en_ff && r_ff == kidx_ff) i_in = w_ff;
            if (!kill) begin
               we = 1'b1;
               w_in = w_ff + 1'b1;
            end
            r_in = r_ff + 1'b1;
            state_in = S_CMP_RD;
         end
         S_READ_RD: begin
            if (CNT_W'(idx_ff) < cnt_ff) begin
               rd_en = 1'b1;
               raddr = IDX_W'(idx_ff);
               state_in = S_READ_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_READ_CHK: begin
            hit_in = 1'b1;
            ent_in = rdata_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit_ff; rsp_chg_in = chg_ff;
               rsp_node_in = ent_ff.node; rsp_via_in = ent_ff.via;
               rsp_hops_in = ent_ff.hops; rsp_cnt_in = 6'(cnt_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; w_ff <= w_in; i_ff <= i_in;
      kidx_ff <= kidx_in; kidx_en_ff <= kidx_en_in; kvia_en_ff <= kvia_en_in;
      op_ff <= op_in; key_ff <= key_in; via_ff <= via_in; now_ff <= now_in;
      hops_ff <= hops_in; idx_ff <= idx_in;
      hit_ff <= hit_in; chg_ff <= chg_in; ent_ff <= ent_in;
      rsp_hit_ff <= rsp_hit_in; rsp_chg_ff <= rsp_chg_in;
      rsp_node_ff <= rsp_node_in; rsp_via_ff <= rsp_via_in;
      rsp_hops_ff <= rsp_hops_in; rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hit = rsp_hit_ff;
   assign rsp_bus.table_changed = rsp_chg_ff;
   assign rsp_bus.out_node = rsp_node_ff;
   assign rsp_bus.out_via_hop = rsp_via_ff;
   assign rsp_bus.out_hop_count = rsp_hops_ff;
   assign rsp_bus.entry_count = rsp_cnt_ff;
endmodule
